FILE: design/b2d_pkg.sv
// Shared constants and types for the binary to decimal digit converter.
package b2d_pkg;

  // Field widths
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 6;
  localparam int DIGIT_W = 4;

  // Digit buffer sizing
  localparam int MAX_DIGITS = 10;
  localparam int DIGIT_BUF  = 10;
  localparam int LIMIT_RAW  = (MAX_DIGITS < DIGIT_BUF) ? MAX_DIGITS : DIGIT_BUF;
  localparam int LIMIT      = (LIMIT_RAW < 1) ? 1 : LIMIT_RAW;
  localparam int DIG_IDX_W  = (LIMIT > 1) ? $clog2(LIMIT) : 1;

  // Divider: quotient bits resolved per cycle
  localparam int DIV_STEP = 4;
  localparam int STEP_N   = VALUE_W / DIV_STEP;
  localparam int STEP_W   = (STEP_N > 1) ? $clog2(STEP_N) : 1;

  localparam int RADIX      = 10;
  localparam int ASCII_ZERO = 48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Request into the divide-by-ten unit
  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
  } div_req_t;

  // Response from the divide-by-ten unit
  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: design/b2d_in_if.sv
// Input channel: one signed integer per transfer.
interface b2d_in_if;
  logic                       valid;
  logic                       ready;
  logic signed [b2d_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

FILE: design/b2d_out_if.sv
// Output channel: one ASCII digit per transfer, flagged on the final digit.
interface b2d_out_if;
  logic                       valid;
  logic                       ready;
  logic [b2d_pkg::CHAR_W-1:0] digit_char;
  logic                       last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

FILE: design/b2d_div10.sv
// Iterative restoring divide-by-ten unit, DIV_STEP quotient bits per cycle.
module b2d_div10 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b2d_pkg::div_req_t req_i,
  output b2d_pkg::div_rsp_t rsp_o
);
  import b2d_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [VALUE_W-1:0] n_q, n_d;
  logic [DIGIT_W-1:0] r_q, r_d;

  // One chunk of shift-and-subtract: dividend bits shift out the top,
  // quotient bits shift in at the bottom of the same register.
  always_comb begin
    logic [DIGIT_W:0]    t;
    logic [DIGIT_W-1:0]  r;
    logic [DIV_STEP-1:0] qb;
    r  = r_q;
    qb = '0;
    t  = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {r, n_q[VALUE_W-1-i]};
      if (t >= (DIGIT_W+1)'(RADIX)) begin
        r                  = DIGIT_W'(t - (DIGIT_W+1)'(RADIX));
        qb[DIV_STEP-1-i]   = 1'b1;
      end else begin
        r = t[DIGIT_W-1:0];
      end
    end

    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    n_d    = n_q;
    r_d    = r_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      n_d    = req_i.dividend;
      r_d    = '0;
    end else if (busy_q) begin
      n_d    = {n_q[VALUE_W-DIV_STEP-1:0], qb};
      r_d    = r;
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(STEP_N - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    r_q <= r_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = n_q;
  assign rsp_o.rem      = r_q;

endmodule

FILE: design/binary_to_decimal_digits.sv
// Top level: sequencer and digit buffer around the shared divide-by-ten unit.
//
// Usage:
//   in_i  carries one signed 32-bit value per transfer. in_i.ready is high
//         only while the block is idle; it drops for the whole conversion.
//   out_o carries the decimal digits as ASCII, most significant first, one
//         per transfer, with last set on the final digit. No sign, no leading
//         zeros. Zero and negative values give the single digit '0'.
// Timing and throughput:
//   A positive value takes one division per digit, up to ten digits; each
//   remainder is written when the divider's registered done flag rises.
//   Zero or negative values skip the divider and show their digit in the
//   cycle after the transfer. Digits then leave at one per cycle while
//   out_o.ready is high; the next value is accepted in the cycle after the
//   last digit's transfer. The divide-by-ten unit sets the pace: DIV_STEP
//   quotient bits per cycle.
// Reset: returns to idle with in_i.ready high; any conversion is dropped.
// Stall: a digit waiting on out_o holds steady until the receiver takes it;
//   the converter simply waits.
module binary_to_decimal_digits (
  input  logic      clk_i,
  input  logic      rst_ni,
  b2d_in_if.sink    in_i,
  b2d_out_if.source out_o
);
  import b2d_pkg::*;

  state_e             state_q, state_d;
  logic [DIG_IDX_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [DIG_IDX_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [DIGIT_W-1:0] buf_q [LIMIT];

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_xfer;
  logic out_xfer;
  logic non_pos;
  logic div_finish;
  logic buf_we;
  logic [DIG_IDX_W-1:0] buf_waddr;
  logic [DIGIT_W-1:0]   buf_wdata;

  b2d_div10 u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign non_pos  = (in_i.value == '0) || in_i.value[VALUE_W-1];
  // Stop dividing when the quotient runs out or the buffer is full
  assign div_finish = (div_rsp.quotient == '0) ||
                      (wr_ptr_q == DIG_IDX_W'(LIMIT - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = non_pos ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done && div_finish) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_xfer && (rd_ptr_q == '0)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = in_i.value;
    buf_we           = 1'b0;
    buf_waddr        = wr_ptr_q;
    buf_wdata        = div_rsp.rem;
    wr_ptr_d         = wr_ptr_q;
    rd_ptr_d         = rd_ptr_q;
    in_i.ready       = 1'b0;
    out_o.valid      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        wr_ptr_d   = '0;
        if (in_xfer) begin
          if (non_pos) begin
            buf_we    = 1'b1;
            buf_waddr = '0;
            buf_wdata = '0;
            rd_ptr_d  = '0;
          end else begin
            div_req.start = 1'b1;
          end
        end
      end
      ST_DIV: begin
        div_req.dividend = div_rsp.quotient;
        if (div_rsp.done) begin
          buf_we = 1'b1;
          if (div_finish) begin
            rd_ptr_d = wr_ptr_q;
          end else begin
            wr_ptr_d      = wr_ptr_q + DIG_IDX_W'(1);
            div_req.start = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        out_o.valid = 1'b1;
        if (out_xfer && (rd_ptr_q != '0)) begin
          rd_ptr_d = rd_ptr_q - DIG_IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_o.digit_char = CHAR_W'(ASCII_ZERO) + CHAR_W'(buf_q[rd_ptr_q]);
  assign out_o.last       = (rd_ptr_q == '0);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      state_q  <= state_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // Digit buffer, least significant digit at entry zero
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_q[buf_waddr] <= buf_wdata;
    end
  end

endmodule

FILE: design/b2d_check.sv
// Port-level assertions for the converter, bound to the top level.
module b2d_check (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [b2d_pkg::VALUE_W-1:0]   in_value_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [b2d_pkg::CHAR_W-1:0]    out_char_i,
  input logic                          out_last_i
);
  import b2d_pkg::*;

  // Input side never opens while a digit is on offer
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while a digit is pending");

  // Every digit is an ASCII decimal character
  a_ascii_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_char_i >= CHAR_W'(ASCII_ZERO)) &&
                    (out_char_i <= CHAR_W'(ASCII_ZERO + 9)))
    else $error("digit out of range");

  // A stalled digit holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_char_i) && $stable(out_last_i)))
    else $error("digit changed under stall");

  // Zero or negative input yields a lone '0' right away
  a_non_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i &&
     ((in_value_i == '0) || in_value_i[VALUE_W-1])) |=>
      (out_valid_i && out_last_i && (out_char_i == CHAR_W'(ASCII_ZERO))))
    else $error("non-positive value not printed as single zero");

  // After the final digit the block is ready again
  a_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> in_ready_i)
    else $error("not ready after final digit");

endmodule

bind binary_to_decimal_digits b2d_check u_b2d_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_value_i  (in_i.value),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.digit_char),
  .out_last_i  (out_o.last)
);
